FILE: design/nbsg_pkg.sv
// nbsg_pkg: shared types, constants and output saturation helpers for the
// softened gravity block; no dependencies

package nbsg_pkg;

   localparam int MAX_BODIES_DEF = 32;
   localparam int BODY_IDX_W     = 6;
   localparam int POS_W          = 32;
   localparam int ITEM_W         = 3 * POS_W;
   localparam int ACC_W          = 64;
   localparam int OUT_W          = 48;
   localparam int RSP_DATA_W     = 248;

   localparam int DIV_W     = 89;
   localparam int DIV_STEPS = 89;
   localparam int ROOT_W    = 49;
   localparam int SQ_W      = 98;
   localparam int SQ_STEPS  = 49;
   localparam int U_W       = 56;
   localparam int MB_W      = 56;
   localparam int CAP_W     = 57;
   localparam int DIFF_W    = 33;
   localparam int SUMSQ_W   = 66;

   localparam logic [CAP_W-1:0] TERM_CAP = 57'h100000000000000;
   localparam logic [31:0] MASS_RST = 32'd65536;
   localparam logic [31:0] SOFT_RST = 32'd2147484;

   localparam logic CSR_IDX_MASS = 1'b0;
   localparam logic CSR_IDX_SOFT = 1'b1;

   localparam logic [OUT_W-1:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [OUT_W-1:0] OUT_NEG_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic                    valid;
      logic [BODY_IDX_W-1:0]   tag_i;
      logic [BODY_IDX_W-1:0]   tag_j;
      logic signed [ACC_W-1:0] tx;
      logic signed [ACC_W-1:0] ty;
      logic signed [ACC_W-1:0] tz;
      logic [CAP_W-1:0]        e;
      logic                    hit;
   } term_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] ax;
      logic signed [ACC_W-1:0] ay;
      logic signed [ACC_W-1:0] az;
      logic [ACC_W-1:0]        en;
      logic                    ovf;
   } acc_type;

   // bit OUT_W is the saturation flag
   function automatic logic [OUT_W:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic [OUT_W:0] r;
      if (v > $signed({17'd0, OUT_POS_MAX[OUT_W-2:0]})) begin
         r = {1'b1, OUT_POS_MAX};
      end else if (v < -$signed({16'd0, OUT_NEG_MIN})) begin
         r = {1'b1, OUT_NEG_MIN};
      end else begin
         r = {1'b0, v[OUT_W-1:0]};
      end
      return r;
   endfunction

   function automatic logic [OUT_W:0] neg_mag(input logic [ACC_W-1:0] e);
      logic [OUT_W:0] r;
      if (e > {16'd0, OUT_NEG_MIN}) begin
         r = {1'b1, OUT_NEG_MIN};
      end else begin
         r = {1'b0, OUT_W'(0) - e[OUT_W-1:0]};
      end
      return r;
   endfunction

endpackage

FILE: design/nbsg_cell.sv
// nbsg_cell: one accumulator cell of the chain, holding one body's sums
// depends on nbsg_pkg

module nbsg_cell import nbsg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     clr,
   input  logic     shift,
   input  term_type term_in,
   output term_type term_out,
   input  acc_type  acc_in,
   output acc_type  acc_out
);

   term_type term_ff;
   term_type term_in_dec;
   acc_type  acc_ff;
   acc_type  acc_in_upd;

   always_comb begin
      term_in_dec = term_in;
      term_in_dec.tag_i = term_in.tag_i - BODY_IDX_W'(1);
      term_in_dec.tag_j = term_in.tag_j - BODY_IDX_W'(1);
   end

   always_comb begin
      acc_in_upd = acc_ff;
      priority if (term_in.tag_i == '0) begin
         acc_in_upd.ax  = acc_ff.ax - term_in.tx;
         acc_in_upd.ay  = acc_ff.ay - term_in.ty;
         acc_in_upd.az  = acc_ff.az - term_in.tz;
         acc_in_upd.en  = acc_ff.en + ACC_W'(term_in.e);
         acc_in_upd.ovf = acc_ff.ovf | term_in.hit;
      end else if (term_in.tag_j == '0) begin
         acc_in_upd.ax  = acc_ff.ax + term_in.tx;
         acc_in_upd.ay  = acc_ff.ay + term_in.ty;
         acc_in_upd.az  = acc_ff.az + term_in.tz;
         acc_in_upd.en  = acc_ff.en + ACC_W'(term_in.e);
         acc_in_upd.ovf = acc_ff.ovf | term_in.hit;
      end else begin
         acc_in_upd = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff.valid <= 1'b0;
      end else begin
         term_ff.valid <= term_in.valid;
      end
      term_ff.tag_i <= term_in_dec.tag_i;
      term_ff.tag_j <= term_in_dec.tag_j;
      term_ff.tx    <= term_in.tx;
      term_ff.ty    <= term_in.ty;
      term_ff.tz    <= term_in.tz;
      term_ff.e     <= term_in.e;
      term_ff.hit   <= term_in.hit;

      priority if (clr) begin
         acc_ff <= '0;
      end else if (shift) begin
         acc_ff <= acc_in;
      end else if (term_in.valid) begin
         acc_ff <= acc_in_upd;
      end
   end

   assign term_out = term_ff;
   assign acc_out  = acc_ff;

endmodule

FILE: design/nbsg_engine.sv
// nbsg_engine: pair sequencer with serial multiplier, divider and square root
// depends on nbsg_pkg

module nbsg_engine import nbsg_pkg::*; #(
   parameter int MAX_BODIES = MAX_BODIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [$clog2(MAX_BODIES+1)-1:0] body_cnt,
   input  logic [31:0]                     mass,
   input  logic [31:0]                     softening,
   output logic [$clog2(MAX_BODIES)-1:0]   rd_addr,
   input  logic [ITEM_W-1:0]               rd_data,
   output term_type                        term_out,
   output logic [ACC_W-1:0]                total,
   output logic                            done
);

   localparam int CNT_W  = $clog2(MAX_BODIES+1);
   localparam int ADDR_W = $clog2(MAX_BODIES);

   typedef enum logic [4:0] {
      E_IDLE, E_RDI, E_RDJ, E_DIFF, E_SQSET, E_SQ, E_SQCHK, E_ROOT, E_UDIV,
      E_USET, E_EMUL, E_ECAP, E_WSET, E_WDIV, E_TSET, E_TMUL, E_TDIV, E_TCAP,
      E_EMIT, E_NEXT, E_DONE
   } eng_state_type;

   eng_state_type state_ff;
   logic [CNT_W-1:0] i_ff, j_ff, n_ff;
   logic [ITEM_W-1:0] pi_ff;
   logic signed [DIFF_W-1:0] d_ff [3];
   logic [DIFF_W-1:0] ad_ff [3];
   logic [1:0] k_ff;
   logic [SUMSQ_W-1:0] s_ff;
   logic [U_W-1:0] u_ff;
   logic [CAP_W-1:0] e_ff;
   logic signed [ACC_W-1:0] t_ff [3];
   logic hit_ff;
   logic [ACC_W-1:0] total_ff;
   term_type term_ff;
   logic done_ff;

   logic [DIV_W-1:0] mul_a_ff, mul_p_ff;
   logic [MB_W-1:0]  mul_b_ff;
   logic [DIV_W-1:0] div_n_ff, div_q_ff;
   logic [ROOT_W-1:0] div_r_ff;
   logic [6:0] div_cnt_ff;
   logic [SQ_W-1:0] sq_op_ff, sq_res_ff, sq_one_ff;
   logic [5:0] sq_cnt_ff;

   logic [ROOT_W-1:0] root;
   logic [ROOT_W:0] div_r2;
   logic div_ge;
   logic [ROOT_W-1:0] div_r_in;
   logic [SQ_W-1:0] sq_t;
   logic sq_ge;
   logic signed [DIFF_W-1:0] d_in [3];
   logic [DIFF_W-1:0] ad_in [3];
   logic [DIV_W-16-1:0] ev;
   logic [ACC_W:0] tot_sum;
   logic [CAP_W-1:0] t_mag;
   logic t_hit;

   assign root   = sq_res_ff[ROOT_W-1:0];
   assign div_r2 = {div_r_ff, div_n_ff[DIV_W-1]};
   assign div_ge = div_r2 >= {1'b0, root};
   assign div_r_in = div_ge ? ROOT_W'(div_r2 - {1'b0, root}) : div_r2[ROOT_W-1:0];
   assign sq_t   = sq_res_ff + sq_one_ff;
   assign sq_ge  = sq_op_ff >= sq_t;
   assign ev     = mul_p_ff[DIV_W-1:16];
   assign tot_sum = {1'b0, total_ff} + (ACC_W+1)'(e_ff);
   assign t_hit  = div_q_ff > DIV_W'(TERM_CAP);
   assign t_mag  = t_hit ? TERM_CAP : div_q_ff[CAP_W-1:0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = $signed({pi_ff[k*POS_W+POS_W-1], pi_ff[k*POS_W +: POS_W]})
                 - $signed({rd_data[k*POS_W+POS_W-1], rd_data[k*POS_W +: POS_W]});
         ad_in[k] = d_in[k][DIFF_W-1] ? DIFF_W'(-d_in[k]) : DIFF_W'(d_in[k]);
      end
   end

   assign rd_addr = (state_ff == E_RDI) ? i_ff[ADDR_W-1:0] : j_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= E_IDLE;
         term_ff.valid <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         term_ff.valid <= 1'b0;
         done_ff       <= 1'b0;
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  n_ff     <= body_cnt;
                  i_ff     <= '0;
                  j_ff     <= CNT_W'(1);
                  total_ff <= '0;
                  state_ff <= (body_cnt < CNT_W'(2)) ? E_DONE : E_RDI;
               end
            end
            E_RDI: state_ff <= E_RDJ;
            E_RDJ: begin
               pi_ff    <= rd_data;
               state_ff <= E_DIFF;
            end
            E_DIFF: begin
               for (int k = 0; k < 3; k++) begin
                  d_ff[k]  <= d_in[k];
                  ad_ff[k] <= ad_in[k];
               end
               s_ff     <= SUMSQ_W'(softening);
               hit_ff   <= 1'b0;
               k_ff     <= '0;
               state_ff <= E_SQSET;
            end
            E_SQSET: begin
               mul_a_ff <= DIV_W'(ad_ff[k_ff]);
               mul_b_ff <= MB_W'(ad_ff[k_ff]);
               mul_p_ff <= '0;
               state_ff <= E_SQ;
            end
            E_SQ: begin
               if (mul_b_ff == '0) begin
                  s_ff <= s_ff + mul_p_ff[SUMSQ_W-1:0];
                  if (k_ff == 2'd2) begin
                     state_ff <= E_SQCHK;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= E_SQSET;
                  end
               end else begin
                  if (mul_b_ff[0]) mul_p_ff <= mul_p_ff + mul_a_ff;
                  mul_a_ff <= mul_a_ff << 1;
                  mul_b_ff <= mul_b_ff >> 1;
               end
            end
            E_SQCHK: begin
               if (s_ff == '0) begin
                  state_ff <= E_NEXT;
               end else begin
                  sq_op_ff  <= {s_ff, 32'd0};
                  sq_res_ff <= '0;
                  sq_one_ff <= SQ_W'(1) << (SQ_W - 2);
                  sq_cnt_ff <= '0;
                  state_ff  <= E_ROOT;
               end
            end
            E_ROOT: begin
               if (sq_ge) begin
                  sq_op_ff  <= sq_op_ff - sq_t;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_one_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_one_ff <= sq_one_ff >> 2;
               sq_cnt_ff <= sq_cnt_ff + 6'd1;
               if (sq_cnt_ff == 6'(SQ_STEPS - 1)) begin
                  div_n_ff   <= {17'd0, mass, 40'd0};
                  div_r_ff   <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= E_UDIV;
               end
            end
            E_UDIV, E_WDIV, E_TDIV: begin
               div_r_ff   <= div_r_in;
               div_n_ff   <= div_n_ff << 1;
               div_q_ff   <= {div_q_ff[DIV_W-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 7'd1;
               if (div_cnt_ff == 7'(DIV_STEPS - 1)) begin
                  unique case (state_ff)
                     E_UDIV:  state_ff <= E_USET;
                     E_WDIV:  state_ff <= E_TSET;
                     default: state_ff <= E_TCAP;
                  endcase
               end
            end
            E_USET: begin
               u_ff     <= div_q_ff[U_W-1:0];
               mul_a_ff <= DIV_W'(div_q_ff[U_W-1:0]);
               mul_b_ff <= MB_W'(mass);
               mul_p_ff <= '0;
               state_ff <= E_EMUL;
            end
            E_EMUL, E_TMUL: begin
               if (mul_b_ff == '0) begin
                  if (state_ff == E_EMUL) begin
                     state_ff <= E_ECAP;
                  end else begin
                     div_n_ff   <= mul_p_ff;
                     div_r_ff   <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= E_TDIV;
                  end
               end else begin
                  if (mul_b_ff[0]) mul_p_ff <= mul_p_ff + mul_a_ff;
                  mul_a_ff <= mul_a_ff << 1;
                  mul_b_ff <= mul_b_ff >> 1;
               end
            end
            E_ECAP: begin
               if (ev > (DIV_W-16)'(TERM_CAP)) begin
                  e_ff   <= TERM_CAP;
                  hit_ff <= 1'b1;
               end else begin
                  e_ff <= ev[CAP_W-1:0];
               end
               k_ff     <= '0;
               state_ff <= E_WSET;
            end
            E_WSET: begin
               total_ff   <= (k_ff == 2'd0) ? (tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0])
                                            : total_ff;
               div_n_ff   <= {8'd0, ad_ff[k_ff], 48'd0};
               div_r_ff   <= '0;
               div_cnt_ff <= '0;
               state_ff   <= E_WDIV;
            end
            E_TSET: begin
               mul_a_ff <= DIV_W'(u_ff);
               mul_b_ff <= MB_W'(div_q_ff[DIFF_W-1:0]);
               mul_p_ff <= '0;
               state_ff <= E_TMUL;
            end
            E_TCAP: begin
               if (t_hit) hit_ff <= 1'b1;
               t_ff[k_ff] <= d_ff[k_ff][DIFF_W-1] ? -$signed(ACC_W'(t_mag))
                                                  : $signed(ACC_W'(t_mag));
               if (k_ff == 2'd2) begin
                  state_ff <= E_EMIT;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= E_WSET;
               end
            end
            E_EMIT: begin
               term_ff.valid <= 1'b1;
               term_ff.tag_i <= BODY_IDX_W'(i_ff);
               term_ff.tag_j <= BODY_IDX_W'(j_ff);
               term_ff.tx    <= t_ff[0];
               term_ff.ty    <= t_ff[1];
               term_ff.tz    <= t_ff[2];
               term_ff.e     <= e_ff;
               term_ff.hit   <= hit_ff;
               state_ff      <= E_NEXT;
            end
            E_NEXT: begin
               if (j_ff == n_ff - CNT_W'(1)) begin
                  if (i_ff + CNT_W'(2) == n_ff) begin
                     state_ff <= E_DONE;
                  end else begin
                     i_ff     <= i_ff + CNT_W'(1);
                     j_ff     <= i_ff + CNT_W'(2);
                     state_ff <= E_RDI;
                  end
               end else begin
                  j_ff     <= j_ff + CNT_W'(1);
                  state_ff <= E_RDI;
               end
            end
            E_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= E_IDLE;
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

   assign term_out = term_ff;
   assign total    = total_ff;
   assign done     = done_ff;

endmodule

FILE: design/nbody_softened_gravity_accel_top.sv
// Softened direct-sum gravity: a batch of up to MAX_BODIES bodies is loaded one
// transaction per cycle; the transaction with tlast closes the batch. Every pair is then
// worked by one shared serial unit (bit-serial multiply, 89-step divide, 49-step
// square root); the cell chain is then flushed, after which one result per body
// streams out at one per cycle unless rsp_tready stalls it. Inputs are held off from
// the closing transaction until the last result of the batch is loaded.
// depends on nbsg_pkg, nbsg_engine, nbsg_cell

module nbody_softened_gravity_accel_top import nbsg_pkg::*; #(
   parameter int MAX_BODIES = MAX_BODIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ITEM_W-1:0]     req_tdata,   // pos_x, pos_y, pos_z
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // body_index, acc_x, acc_y, acc_z,
                                              // pot_energy, total_energy, overflow
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W  = $clog2(MAX_BODIES+1);
   localparam int ADDR_W = $clog2(MAX_BODIES);

   typedef enum logic [2:0] {T_LOAD, T_START, T_RUN, T_FLUSH, T_DRAIN} top_state_type;

   top_state_type state_ff;
   logic [CNT_W-1:0] count_ff, b_ff, flush_ff;
   logic [31:0] mass_ff, soft_ff;
   logic [ITEM_W-1:0] mem [MAX_BODIES];
   logic [ITEM_W-1:0] rd_data_ff;
   logic rsp_valid_ff, rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [ADDR_W-1:0] rd_addr;
   logic [ACC_W-1:0] total;
   logic eng_done, eng_start, clr, shift, req_fire, final_body;
   term_type term_c [MAX_BODIES+1];
   acc_type  acc_c [MAX_BODIES+1];

   logic [OUT_W:0] sx, sy, sz, sp, st;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SOFT) ? soft_ff : mass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= MASS_RST;
         soft_ff <= SOFT_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[2])
            CSR_IDX_MASS: mass_ff <= csr_pwdata;
            CSR_IDX_SOFT: soft_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == T_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign eng_start  = (state_ff == T_START);
   assign clr        = eng_start;
   assign shift      = (state_ff == T_DRAIN) && (!rsp_valid_ff || rsp_tready);
   assign final_body = (b_ff == count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (req_fire && count_ff < CNT_W'(MAX_BODIES)) begin
         mem[count_ff[ADDR_W-1:0]] <= req_tdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   nbsg_engine #(.MAX_BODIES(MAX_BODIES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start),
      .body_cnt  (count_ff),
      .mass      (mass_ff),
      .softening (soft_ff),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data_ff),
      .term_out  (term_c[0]),
      .total     (total),
      .done      (eng_done)
   );

   assign acc_c[MAX_BODIES] = '0;

   for (genvar g = 0; g < MAX_BODIES; g++) begin : g_cell
      nbsg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clr      (clr),
         .shift    (shift),
         .term_in  (term_c[g]),
         .term_out (term_c[g+1]),
         .acc_in   (acc_c[g+1]),
         .acc_out  (acc_c[g])
      );
   end

   always_comb begin
      sx = sat_out(acc_c[0].ax);
      sy = sat_out(acc_c[0].ay);
      sz = sat_out(acc_c[0].az);
      sp = neg_mag(acc_c[0].en);
      st = final_body ? neg_mag(total) : '0;
      rsp_data_in = {1'b0,
                     acc_c[0].ovf | sx[OUT_W] | sy[OUT_W] | sz[OUT_W] | sp[OUT_W] | st[OUT_W],
                     st[OUT_W-1:0], sp[OUT_W-1:0], sz[OUT_W-1:0], sy[OUT_W-1:0],
                     sx[OUT_W-1:0], BODY_IDX_W'(b_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         count_ff     <= '0;
         b_ff         <= '0;
         flush_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (shift) begin
            rsp_valid_ff <= 1'b1;
            rsp_last_ff  <= final_body;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_LOAD: begin
               if (req_fire) begin
                  if (count_ff < CNT_W'(MAX_BODIES)) count_ff <= count_ff + CNT_W'(1);
                  if (req_tlast) state_ff <= T_START;
               end
            end
            T_START: state_ff <= T_RUN;
            T_RUN: begin
               flush_ff <= '0;
               if (eng_done) state_ff <= T_FLUSH;
            end
            T_FLUSH: begin
               flush_ff <= flush_ff + CNT_W'(1);
               if (flush_ff == CNT_W'(MAX_BODIES)) begin
                  b_ff     <= '0;
                  state_ff <= T_DRAIN;
               end
            end
            T_DRAIN: begin
               if (shift) begin
                  b_ff <= b_ff + CNT_W'(1);
                  if (final_body) begin
                     count_ff <= '0;
                     state_ff <= T_LOAD;
                  end
               end
            end
            default: state_ff <= T_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/nbsg_checker.sv
// nbsg_checker: port-level assertions for the gravity block, bound to the top
// depends on nbsg_pkg and nbody_softened_gravity_accel_top

module nbsg_checker import nbsg_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no input while a batch is still draining
   a_no_input_in_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken during drain");

   // results of a batch follow back to back
   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a batch");

   // total energy shows only on the final result
   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[245:198] == '0)
      else $error("total energy on a non-final result");

endmodule

bind nbody_softened_gravity_accel_top nbsg_checker u_nbsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
